// ===== design/prcl_pkg.sv =====
package prcl_pkg;

   // Configuration register map
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POINT_LAT = 1'b0,
      CSR_POINT_LON = 1'b1
   } csr_index_type;

   // Item kinds on the request channel
   typedef enum logic {
      ACTION_VERTEX = 1'b0,
      ACTION_MARKER = 1'b1
   } action_type;

   // What an item does once its edge has been tested
   typedef struct packed {
      logic is_marker;
      logic has_edge;
   } item_ctrl_type;

   // Geometric tests of one edge against the reference point
   typedef struct packed {
      logic in_band;   // lon within (ylo, yhi] and lat not beyond the far end
      logic flat;      // edge runs along constant longitude value y1 == y2
      logic vertical;  // x1 == x2
      logic rising;    // y2 > y1
   } edge_test_type;

endpackage

// ===== design/prcl_if.sv =====
interface prcl_req_if #(
   parameter int COORD_BITS = 32
) ();
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic signed [COORD_BITS-2:0] vertex_lat;
   logic signed [COORD_BITS-1:0] vertex_lon;

   modport source (output valid, action, vertex_lat, vertex_lon, input ready);
   modport sink   (input valid, action, vertex_lat, vertex_lon, output ready);
endinterface

interface prcl_rsp_if #(
   parameter int POLY_INDEX_BITS = 8
) ();
   logic                       valid;
   logic                       ready;
   logic [POLY_INDEX_BITS-1:0] hit_polygon;
   logic                       decided;

   modport source (output valid, hit_polygon, decided, input ready);
   modport sink   (input valid, hit_polygon, decided, output ready);
endinterface

interface prcl_csr_if
   import prcl_pkg::*;
#(
   parameter int COORD_BITS = 32
) ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [COORD_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/prcl_edge_capture.sv =====
module prcl_edge_capture
   import prcl_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         action,
   input  logic signed [COORD_BITS-2:0] vertex_lat,
   input  logic signed [COORD_BITS-1:0] vertex_lon,
   input  logic                         take,
   output logic                         valid_ff,
   output item_ctrl_type                ctrl_ff,
   output logic signed [COORD_BITS-2:0] x1_ff,
   output logic signed [COORD_BITS-1:0] y1_ff,
   output logic signed [COORD_BITS-2:0] x2_ff,
   output logic signed [COORD_BITS-1:0] y2_ff
);

   logic                         awaiting_ff, awaiting_in;
   logic signed [COORD_BITS-2:0] first_lat_ff, first_lat_in;
   logic signed [COORD_BITS-1:0] first_lon_ff, first_lon_in;
   logic signed [COORD_BITS-2:0] prev_lat_ff, prev_lat_in;
   logic signed [COORD_BITS-1:0] prev_lon_ff, prev_lon_in;
   item_ctrl_type                ctrl_in;
   logic signed [COORD_BITS-2:0] x2_in;
   logic signed [COORD_BITS-1:0] y2_in;
   logic                         valid_in;

   // Form the edge this item tests and advance the polygon walk
   always_comb begin
      awaiting_in       = awaiting_ff;
      first_lat_in      = first_lat_ff;
      first_lon_in      = first_lon_ff;
      prev_lat_in       = prev_lat_ff;
      prev_lon_in       = prev_lon_ff;
      ctrl_in.has_edge  = !awaiting_ff;
      ctrl_in.is_marker = (action == ACTION_MARKER);
      if (action == ACTION_MARKER) begin
         // close back to the first vertex
         x2_in       = first_lat_ff;
         y2_in       = first_lon_ff;
         awaiting_in = 1'b1;
      end else begin
         x2_in       = vertex_lat;
         y2_in       = vertex_lon;
         prev_lat_in = vertex_lat;
         prev_lon_in = vertex_lon;
         if (awaiting_ff) begin
            first_lat_in = vertex_lat;
            first_lon_in = vertex_lon;
            awaiting_in  = 1'b0;
         end
      end
   end

   // Hold the stage until the multiply stage takes it
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         awaiting_ff <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            awaiting_ff <= awaiting_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_lat_ff <= first_lat_in;
         first_lon_ff <= first_lon_in;
         prev_lat_ff  <= prev_lat_in;
         prev_lon_ff  <= prev_lon_in;
         ctrl_ff      <= ctrl_in;
         x1_ff        <= prev_lat_ff;
         y1_ff        <= prev_lon_ff;
         x2_ff        <= x2_in;
         y2_ff        <= y2_in;
      end
   end

endmodule

// ===== design/prcl_cross_mult.sv =====
module prcl_cross_mult
   import prcl_pkg::*;
#(
   parameter int COORD_BITS = 32,
   localparam int DIFF_BITS = COORD_BITS + 1,
   localparam int PROD_BITS = 2 * DIFF_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-2:0] point_lat,
   input  logic signed [COORD_BITS-1:0] point_lon,
   input  logic                         in_valid,
   input  item_ctrl_type                in_ctrl,
   input  logic signed [COORD_BITS-2:0] x1,
   input  logic signed [COORD_BITS-1:0] y1,
   input  logic signed [COORD_BITS-2:0] x2,
   input  logic signed [COORD_BITS-1:0] y2,
   input  logic                         out_take,
   output logic                         in_take,
   output logic                         valid_ff,
   output item_ctrl_type                ctrl_ff,
   output edge_test_type                test_ff,
   output logic signed [PROD_BITS-1:0]  prod_p_ff,
   output logic signed [PROD_BITS-1:0]  prod_q_ff
);

   logic signed [DIFF_BITS-1:0]  dx_pt, dy_edge, dy_pt, dx_edge;
   logic signed [PROD_BITS-1:0]  prod_p_in, prod_q_in;
   logic signed [COORD_BITS-1:0] y_lo, y_hi;
   logic signed [COORD_BITS-2:0] x_hi;
   edge_test_type                test_in;
   logic                         valid_in;

   // Cross-multiplied form of the intercept compare
   always_comb begin
      dx_pt     = DIFF_BITS'(point_lat) - DIFF_BITS'(x1);
      dy_edge   = DIFF_BITS'(y2) - DIFF_BITS'(y1);
      dy_pt     = DIFF_BITS'(point_lon) - DIFF_BITS'(y1);
      dx_edge   = DIFF_BITS'(x2) - DIFF_BITS'(x1);
      prod_p_in = PROD_BITS'(dx_pt) * PROD_BITS'(dy_edge);
      prod_q_in = PROD_BITS'(dy_pt) * PROD_BITS'(dx_edge);
   end

   // Band and end-point tests
   always_comb begin
      y_lo             = (y1 < y2) ? y1 : y2;
      y_hi             = (y1 < y2) ? y2 : y1;
      x_hi             = (x1 < x2) ? x2 : x1;
      test_in.in_band  = (point_lon > y_lo) && (point_lon <= y_hi) && (point_lat <= x_hi);
      test_in.flat     = (y1 == y2);
      test_in.vertical = (x1 == x2);
      test_in.rising   = (y2 > y1);
   end

   assign in_take = in_valid && (!valid_ff || out_take);

   always_comb begin
      valid_in = valid_ff;
      if (in_take) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         ctrl_ff   <= in_ctrl;
         test_ff   <= test_in;
         prod_p_ff <= prod_p_in;
         prod_q_ff <= prod_q_in;
      end
   end

endmodule

// ===== design/prcl_decide.sv =====
module prcl_decide
   import prcl_pkg::*;
#(
   parameter int COORD_BITS      = 32,
   parameter int POLY_INDEX_BITS = 8,
   localparam int PROD_BITS      = 2 * (COORD_BITS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  item_ctrl_type               in_ctrl,
   input  edge_test_type               in_test,
   input  logic signed [PROD_BITS-1:0] prod_p,
   input  logic signed [PROD_BITS-1:0] prod_q,
   input  logic                        out_ready,
   output logic                        in_take,
   output logic                        out_valid_ff,
   output logic [POLY_INDEX_BITS-1:0]  hit_ff,
   output logic                        decided_ff
);

   logic                       inside_ff, inside_in;
   logic                       found_ff, found_in;
   logic [POLY_INDEX_BITS-1:0] poly_ff, poly_in;
   logic                       crossing;
   logic                       out_valid_in;

   // Ray crossing: flip the sense of the compare for a falling edge
   always_comb begin
      crossing = in_test.in_band && !in_test.flat &&
                 (in_test.vertical ||
                  (in_test.rising ? (prod_p <= prod_q) : (prod_p >= prod_q)));
   end

   // Toggle inside, latch on a closing marker, else count the polygon
   always_comb begin
      inside_in = inside_ff;
      found_in  = found_ff;
      poly_in   = poly_ff;
      if (!found_ff) begin
         inside_in = inside_ff ^ (in_ctrl.has_edge && crossing);
         if (in_ctrl.is_marker) begin
            if (in_ctrl.has_edge && inside_in) begin
               found_in = 1'b1;
            end else begin
               poly_in = poly_ff + POLY_INDEX_BITS'(1);
            end
         end
      end
   end

   assign in_take = in_valid && (!out_valid_ff || out_ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (in_take) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         inside_ff    <= 1'b0;
         found_ff     <= 1'b0;
         poly_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (in_take) begin
            inside_ff <= inside_in;
            found_ff  <= found_in;
            poly_ff   <= poly_in;
         end
      end
   end

   // Result transaction: polygon number only once latched
   always_ff @(posedge clock) begin
      if (in_take) begin
         hit_ff     <= found_in ? poly_in : '0;
         decided_ff <= found_in;
      end
   end

endmodule

// ===== design/polygon_ray_cast_locator.sv =====
// Point-in-polygon locator by ray casting over a vertex stream.
// Configure the reference point through csr_bus (index CSR_POINT_LAT, then
// CSR_POINT_LON) while no request is in flight; csr_bus is always ready.
// Each req_bus transaction is a vertex or a polygon separator marker. The
// first vertex after reset or a marker opens a polygon; each further vertex
// tests one edge, and a marker tests the closing edge back to the first one.
// Every request produces exactly one rsp_bus transaction carrying decided and
// hit_polygon (the marker count at the time the point was found inside).
// After the first hit all later requests return the same latched result.
// Path: an accepted request loads the capture register, then the
// cross-multiply register, then the result register behind rsp_bus.valid;
// a stalled stage holds it in place. Throughput: one request per cycle
// while rsp_bus is ready; the multiply stage is fully pipelined.
// A stalled rsp_bus fills the three stages, then req_bus.ready drops; each
// stage moves as soon as the one after it frees up.
// Reset clears the point to zero, the polygon count, the inside bit and the
// latch, and empties the pipeline; the block is ready right after reset.
module polygon_ray_cast_locator
   import prcl_pkg::*;
#(
   parameter int COORD_BITS      = 32,
   parameter int POLY_INDEX_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   prcl_req_if.sink    req_bus,
   prcl_rsp_if.source  rsp_bus,
   prcl_csr_if.sink    csr_bus
);

   localparam int PROD_BITS = 2 * (COORD_BITS + 1);

   logic signed [COORD_BITS-2:0] point_lat_ff;
   logic signed [COORD_BITS-1:0] point_lon_ff;

   logic                         req_accept;
   logic                         cap_valid, cap_take;
   item_ctrl_type                cap_ctrl;
   logic signed [COORD_BITS-2:0] cap_x1, cap_x2;
   logic signed [COORD_BITS-1:0] cap_y1, cap_y2;
   logic                         mul_valid, mul_take;
   item_ctrl_type                mul_ctrl;
   edge_test_type                mul_test;
   logic signed [PROD_BITS-1:0]  mul_p, mul_q;

   // Configuration writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_lat_ff <= '0;
         point_lon_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_POINT_LAT: point_lat_ff <= csr_bus.data[COORD_BITS-2:0];
            CSR_POINT_LON: point_lon_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Request side: take a transaction whenever the capture stage frees up
   assign req_bus.ready = !cap_valid || cap_take;
   assign req_accept    = req_bus.valid && req_bus.ready;

   prcl_edge_capture #(
      .COORD_BITS (COORD_BITS)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .action     (req_bus.action),
      .vertex_lat (req_bus.vertex_lat),
      .vertex_lon (req_bus.vertex_lon),
      .take       (cap_take),
      .valid_ff   (cap_valid),
      .ctrl_ff    (cap_ctrl),
      .x1_ff      (cap_x1),
      .y1_ff      (cap_y1),
      .x2_ff      (cap_x2),
      .y2_ff      (cap_y2)
   );

   prcl_cross_mult #(
      .COORD_BITS (COORD_BITS)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .point_lat (point_lat_ff),
      .point_lon (point_lon_ff),
      .in_valid  (cap_valid),
      .in_ctrl   (cap_ctrl),
      .x1        (cap_x1),
      .y1        (cap_y1),
      .x2        (cap_x2),
      .y2        (cap_y2),
      .out_take  (mul_take),
      .in_take   (cap_take),
      .valid_ff  (mul_valid),
      .ctrl_ff   (mul_ctrl),
      .test_ff   (mul_test),
      .prod_p_ff (mul_p),
      .prod_q_ff (mul_q)
   );

   prcl_decide #(
      .COORD_BITS      (COORD_BITS),
      .POLY_INDEX_BITS (POLY_INDEX_BITS)
   ) u_decide (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mul_valid),
      .in_ctrl      (mul_ctrl),
      .in_test      (mul_test),
      .prod_p       (mul_p),
      .prod_q       (mul_q),
      .out_ready    (rsp_bus.ready),
      .in_take      (mul_take),
      .out_valid_ff (rsp_bus.valid),
      .hit_ff       (rsp_bus.hit_polygon),
      .decided_ff   (rsp_bus.decided)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import prcl_pkg::*;

   localparam int COORD_BITS      = 32;
   localparam int POLY_INDEX_BITS = 8;
   localparam longint LAT_MAX = (longint'(1) << (COORD_BITS - 2)) - 1;
   localparam longint LAT_MIN = -(longint'(1) << (COORD_BITS - 2));
   localparam longint LON_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint LON_MIN = -(longint'(1) << (COORD_BITS - 1));
   localparam int ITEMS_PER_PHASE = 220;
   localparam int SQUEEZE_CYCLES  = 64;
   localparam int SQUEEZE_BURST   = 24;
   localparam int RANDOM_PHASES   = 6;

   // Wrap a coordinate to the field width and read it back as signed
   function automatic longint fit_lat(longint v);
      logic [COORD_BITS-2:0] t;
      t = v[COORD_BITS-2:0];
      return $signed(t);
   endfunction

   function automatic longint fit_lon(longint v);
      logic [COORD_BITS-1:0] t;
      t = v[COORD_BITS-1:0];
      return $signed(t);
   endfunction

   // Tracks the locator state and holds the verdicts still owed by the block
   class locator_scoreboard;
      typedef struct packed {
         logic [POLY_INDEX_BITS-1:0] hit_polygon;
         logic                       decided;
      } verdict_type;

      verdict_type expected_verdicts[$];
      longint pt_lat, pt_lon;
      longint first_lat, first_lon, prev_lat, prev_lon;
      bit inside_now, awaiting_first, latched;
      logic [POLY_INDEX_BITS-1:0] poly_count;
      int errors, responses, closed_polygons, crossings;

      function new();
         pt_lat = 0;
         pt_lon = 0;
         first_lat = 0;
         first_lon = 0;
         prev_lat = 0;
         prev_lon = 0;
         inside_now = 0;
         awaiting_first = 1;
         latched = 0;
         poly_count = '0;
         errors = 0;
         responses = 0;
         closed_polygons = 0;
         crossings = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [COORD_BITS-1:0] data);
         case (idx)
            CSR_POINT_LAT: pt_lat = $signed(data[COORD_BITS-2:0]);
            CSR_POINT_LON: pt_lon = $signed(data);
            default: ;
         endcase
      endfunction

      // Ray-crossing test, with the intercept compared by cross-multiplication
      function bit edge_crosses(longint x1, longint y1, longint x2, longint y2);
         longint ylo, yhi, xhi;
         logic signed [67:0] dx, dy, ey, ex, lhs, rhs;
         ylo = (y1 < y2) ? y1 : y2;
         yhi = (y1 < y2) ? y2 : y1;
         xhi = (x1 < x2) ? x2 : x1;
         if (!(pt_lon > ylo && pt_lon <= yhi && pt_lat <= xhi)) return 1'b0;
         if (y1 == y2) return 1'b0;
         if (x1 == x2) return 1'b1;
         dx = pt_lat - x1;
         dy = y2 - y1;
         ey = pt_lon - y1;
         ex = x2 - x1;
         lhs = dx * dy;
         rhs = ey * ex;
         return (y2 > y1) ? (lhs <= rhs) : (lhs >= rhs);
      endfunction

      // Crossing parity of a closed ring against the current point
      function bit ring_parity(longint lat[$], longint lon[$]);
         bit p;
         int n;
         p = 1'b0;
         n = lat.size();
         if (n == 0) return 1'b0;
         for (int i = 1; i < n; i++)
            p ^= edge_crosses(lat[i-1], lon[i-1], lat[i], lon[i]);
         p ^= edge_crosses(lat[n-1], lon[n-1], lat[0], lon[0]);
         return p;
      endfunction

      function void note_request(action_type act, logic [COORD_BITS-2:0] lat_bits,
                                 logic [COORD_BITS-1:0] lon_bits);
         longint lat, lon;
         verdict_type v;
         lat = $signed(lat_bits);
         lon = $signed(lon_bits);
         if (!latched) begin
            if (act == ACTION_MARKER) begin
               // close the open ring with its first vertex
               if (!awaiting_first) begin
                  if (edge_crosses(prev_lat, prev_lon, first_lat, first_lon)) begin
                     inside_now = !inside_now;
                     crossings++;
                  end
                  closed_polygons++;
                  if (inside_now) latched = 1'b1;
               end
               if (!latched) begin
                  poly_count++;
                  awaiting_first = 1'b1;
               end
            end else begin
               if (awaiting_first) begin
                  first_lat = lat;
                  first_lon = lon;
                  awaiting_first = 1'b0;
               end else if (edge_crosses(prev_lat, prev_lon, lat, lon)) begin
                  inside_now = !inside_now;
                  crossings++;
               end
               prev_lat = lat;
               prev_lon = lon;
            end
         end
         v.decided = latched;
         v.hit_polygon = latched ? poly_count : '0;
         expected_verdicts.push_back(v);
      endfunction

      function void check_response(logic [POLY_INDEX_BITS-1:0] hit, logic decided);
         verdict_type want;
         responses++;
         if (expected_verdicts.size() == 0) begin
            $error("unexpected response: hit_polygon %0d decided %0d", hit, decided);
            errors++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (hit !== want.hit_polygon) begin
            $error("hit_polygon: expected %0d, actual %0d", want.hit_polygon, hit);
            errors++;
         end
         if (decided !== want.decided) begin
            $error("decided: expected %0d, actual %0d", want.decided, decided);
            errors++;
         end
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   prcl_req_if #(.COORD_BITS(COORD_BITS))           req_bus ();
   prcl_rsp_if #(.POLY_INDEX_BITS(POLY_INDEX_BITS)) rsp_bus ();
   prcl_csr_if #(.COORD_BITS(COORD_BITS))           csr_bus ();

   locator_scoreboard sb;
   bit calm;
   bit squeeze_pending;
   int burst_left;
   int items_sent;

   polygon_ray_cast_locator #(
      .COORD_BITS(COORD_BITS),
      .POLY_INDEX_BITS(POLY_INDEX_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watch all three channels; check results before noting new requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.hit_polygon, rsp_bus.decided);
         if (req_bus.valid && req_bus.ready)
            sb.note_request(action_type'(req_bus.action), req_bus.vertex_lat,
                            req_bus.vertex_lon);
         if (csr_bus.valid && csr_bus.ready)
            sb.write_register(csr_index_type'(csr_bus.index), csr_bus.data);
      end
   end

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 0;
      if (r < 15) return 1;
      if (r < 25) return 2;
      return $urandom_range(3, 9);
   endfunction

   function automatic longint pick_radius();
      case ($urandom_range(0, 4))
         0: return 2;
         1: return 16;
         2: return 5000;
         3: return longint'(1) << 20;
         default: return longint'(1) << 30;
      endcase
   endfunction

   function automatic longint jitter(longint r);
      return longint'($urandom_range(0, 32'(2 * r))) - r;
   endfunction

   // Ring around the point with ties on lat, lon and repeated axes, or random vertices if noise
   function automatic void make_polygon(output longint lat[$], output longint lon[$],
                                        input int n, input longint radius, input bit noise);
      longint a, b;
      lat.delete();
      lon.delete();
      repeat (n) begin
         if (noise) begin
            a = fit_lat($urandom);
            b = fit_lon($urandom);
         end else begin
            a = fit_lat(sb.pt_lat + jitter(radius));
            b = fit_lon(sb.pt_lon + jitter(radius));
            case ($urandom_range(0, 9))
               0: a = sb.pt_lat;
               1: b = sb.pt_lon;
               2: if (lat.size() > 0) a = lat[$];
               3: if (lon.size() > 0) b = lon[$];
               default: ;
            endcase
         end
         lat.push_back(a);
         lon.push_back(b);
      end
   endfunction

   // Result pacing: random stalls, plus one long hold-off on request
   initial begin : rsp_pacing
      int stall_left;
      int g;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (squeeze_pending) begin
            squeeze_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            stall_left = SQUEEZE_CYCLES - 1;
         end else begin
            g = calm ? 0 : pick_gap();
            if (g > 0) begin
               rsp_bus.ready <= 1'b0;
               stall_left = g - 1;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [COORD_BITS-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Unused top bit of the latitude word gets random junk
   task automatic write_point(longint lat, longint lon);
      write_csr(CSR_POINT_LAT, {1'($urandom_range(0, 1)), lat[COORD_BITS-2:0]});
      write_csr(CSR_POINT_LON, lon[COORD_BITS-1:0]);
   endtask

   // Offer one transaction and hold it until accepted
   task automatic send_item(action_type act, longint lat, longint lon);
      int gap;
      gap = (calm || burst_left > 0) ? 0 : pick_gap();
      if (burst_left > 0) burst_left--;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.vertex_lat <= lat[COORD_BITS-2:0];
      req_bus.vertex_lon <= lon[COORD_BITS-1:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Walk the ring twice when one lap would put the point inside and no hit is allowed
   task automatic send_polygon(longint lat[$], longint lon[$], bit allow_hit);
      int laps;
      laps = (!allow_hit && sb.ring_parity(lat, lon)) ? 2 : 1;
      repeat (laps)
         foreach (lat[i]) send_item(ACTION_VERTEX, lat[i], lon[i]);
      send_item(ACTION_MARKER, $urandom, $urandom);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Field extremes, bare markers, single vertices, ties on the point
   task automatic directed_items();
      longint lat[$], lon[$];
      send_item(ACTION_MARKER, -1, -1);
      lat = '{LAT_MAX};
      lon = '{LON_MAX};
      send_polygon(lat, lon, 1'b0);
      lat = '{LAT_MIN};
      lon = '{LON_MIN};
      send_polygon(lat, lon, 1'b0);
      lat = '{LAT_MIN, LAT_MAX, LAT_MAX, LAT_MIN};
      lon = '{LON_MIN, LON_MIN, LON_MAX, LON_MAX};
      send_polygon(lat, lon, 1'b0);
      lat = '{0, 0, 5, 5};
      lon = '{0, 5, 5, 0};
      send_polygon(lat, lon, 1'b0);
      send_item(ACTION_MARKER, 0, 0);
      send_item(ACTION_MARKER, LAT_MAX, LON_MIN);
   endtask

   task automatic random_phase(int count);
      longint lat[$], lon[$];
      int target;
      bit squeezed;
      target = items_sent + count;
      squeezed = 1'b0;
      while (items_sent < target) begin
         // halfway through, stall the result side while requests keep coming
         if (!squeezed && items_sent >= target - count / 2) begin
            squeeze_pending = 1'b1;
            burst_left = SQUEEZE_BURST;
            squeezed = 1'b1;
         end
         if ($urandom_range(0, 7) == 0) calm = !calm;
         make_polygon(lat, lon, pick_count(), pick_radius(), $urandom_range(0, 9) == 0);
         send_polygon(lat, lon, 1'b0);
      end
   endtask

   initial begin : stimulus
      longint lat[$], lon[$];
      longint phase_lat[RANDOM_PHASES];
      longint phase_lon[RANDOM_PHASES];
      int goal, pads, tries;
      phase_lat = '{0, 900000000, -900000000, LAT_MAX, LAT_MIN, 0};
      phase_lon = '{0, 1800000000, -1800000000, LON_MAX, LON_MIN, 0};
      phase_lat[RANDOM_PHASES-1] = longint'($urandom_range(0, 1800000000)) - 900000000;
      phase_lon[RANDOM_PHASES-1] = longint'($urandom_range(0, 3600000000)) - 1800000000;
      sb = new();
      calm = 1'b0;
      squeeze_pending = 1'b0;
      burst_left = 0;
      items_sent = 0;
      req_bus.valid = 1'b0;
      req_bus.action = ACTION_VERTEX;
      req_bus.vertex_lat = '0;
      req_bus.vertex_lon = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_POINT_LAT;
      csr_bus.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one point setting per phase, written only while drained
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_point(phase_lat[p], phase_lon[p]);
         if (p == 0) directed_items();
         random_phase(ITEMS_PER_PHASE);
         drain();
      end

      // final phase: advance the count to a chosen number, then enclose the point
      write_point(longint'($urandom_range(0, 1600000000)) - 800000000,
                  longint'($urandom_range(0, 3400000000)) - 1700000000);
      goal = $urandom_range(0, 1) ? 0 : $urandom_range(1, 255);
      pads = (goal - int'(sb.poly_count) + 256) % 256;
      repeat (pads) send_item(ACTION_MARKER, $urandom, $urandom);
      tries = 0;
      do begin
         make_polygon(lat, lon, $urandom_range(3, 9), pick_radius(), 1'b0);
         tries++;
      end while (!sb.ring_parity(lat, lon) && tries < 200);
      if (!sb.ring_parity(lat, lon)) begin
         lat = '{sb.pt_lat - 1, sb.pt_lat + 1, sb.pt_lat + 1, sb.pt_lat - 1};
         lon = '{sb.pt_lon - 1, sb.pt_lon - 1, sb.pt_lon + 1, sb.pt_lon + 1};
      end
      send_polygon(lat, lon, 1'b1);

      // everything after the hit must be ignored
      repeat (8) begin
         make_polygon(lat, lon, pick_count(), pick_radius(), $urandom_range(0, 3) == 0);
         send_polygon(lat, lon, 1'b1);
      end
      drain();

      $display("Sent %0d transactions over %0d point settings; %0d rings closed, %0d crossings",
               items_sent, RANDOM_PHASES + 1, sb.closed_polygons, sb.crossings);
      $display("Checked %0d results; final verdict polygon %0d, decided %0d",
               sb.responses, sb.poly_count, sb.latched);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Hard stop if the handshakes never complete
   initial begin : watchdog
      #10_000_000;
      $error("run timed out with %0d results outstanding", sb.pending());
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/prcl_pkg.sv
design/prcl_if.sv
design/prcl_edge_capture.sv
design/prcl_cross_mult.sv
design/prcl_decide.sv
design/polygon_ray_cast_locator.sv
bench/tb_top.sv
